[src/mpcm_pkg.sv]
// Shared types, codes and constants for the multi-pattern command matcher.
// Used by every module under src; depends on nothing else.
`timescale 1ns / 1ps

package mpcm_pkg;

    // Item kinds on the input channel
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // End reasons reported with a data byte
    localparam logic [1:0] END_NONE    = 2'd0;
    localparam logic [1:0] END_HANDLER = 2'd1;
    localparam logic [1:0] END_LIMIT   = 2'd2;

    // Register indexes (byte address is 8 * index)
    localparam int ADDR_W = 6;
    localparam logic [2:0] REG_COUNT   = 3'd0;
    localparam logic [2:0] REG_TEXT0   = 3'd1;
    localparam logic [2:0] REG_TEXT1   = 3'd2;
    localparam logic [2:0] REG_TEXT2   = 3'd3;
    localparam logic [2:0] REG_TEXT3   = 3'd4;
    localparam logic [2:0] REG_MAX_LEN = 3'd5;
    localparam logic [2:0] REG_TIMEOUT = 3'd6;

    localparam int NUM_TEXT    = 4;
    localparam int TEXT_W      = 64;
    localparam int DATA_W      = 64;
    localparam int CNT_W       = 16;
    localparam int PROG_W      = 4;
    localparam int IDX_W       = 2;
    localparam int QUEUE_DEPTH = 4;

    localparam int NUM_PATTERNS_DEF    = 4;
    localparam int MAX_PATTERN_LEN_DEF = 8;

    localparam logic [2:0]       DEF_COUNT   = 3'd4;
    localparam logic [CNT_W-1:0] DEF_MAX_LEN = 16'd256;
    localparam logic [CNT_W-1:0] DEF_TIMEOUT = 16'd3000;

    typedef struct packed {
        logic       is_tick;
        logic [7:0] ch;
        logic       hend;
    } cmd_t;

    typedef struct packed {
        logic [2:0]                          count;
        logic [NUM_TEXT-1:0][TEXT_W-1:0]     text;
        logic [NUM_TEXT-1:0][PROG_W-1:0]     len;
        logic [CNT_W-1:0]                    max_len;
        logic [CNT_W-1:0]                    timeout;
    } cfg_t;

    typedef struct packed {
        logic             matched;
        logic [IDX_W-1:0] pattern_index;
        logic             in_data;
        logic [7:0]       data_out;
        logic [CNT_W-1:0] data_count;
        logic             timed_out;
        logic [1:0]       end_reason;
    } result_t;

    // Byte number idx of a packed string
    function automatic logic [7:0] pat_byte(input logic [TEXT_W-1:0] t,
                                            input logic [2:0] idx);
        pat_byte = t[{idx, 3'b000} +: 8];
    endfunction

    // Length of a string: position of the first zero byte, at most max_len
    function automatic logic [PROG_W-1:0] text_len(input logic [TEXT_W-1:0] t,
                                                   input int max_len);
        logic found;
        found = 1'b0;
        text_len = PROG_W'(max_len);
        for (int p = 0; p < 8; p++) begin
            if (p < max_len && !found && t[8*p +: 8] == 8'd0) begin
                text_len = PROG_W'(p);
                found = 1'b1;
            end
        end
    endfunction

endpackage

[src/mpcm_cfg_regs.sv]
// Configuration register file of the command matcher, with an APB-style port.
// Depends on mpcm_pkg; pattern lengths are worked out once, when a string is written.
`timescale 1ns / 1ps

module mpcm_cfg_regs
    import mpcm_pkg::*;
#(
    parameter int MAX_PATTERN_LEN = MAX_PATTERN_LEN_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic [2:0]                      count_reg;
    logic [NUM_TEXT-1:0][TEXT_W-1:0] text_reg;
    logic [NUM_TEXT-1:0][PROG_W-1:0] len_reg;
    logic [CNT_W-1:0]                max_len_reg;
    logic [CNT_W-1:0]                timeout_reg;
    logic [2:0]                      idx;
    logic                            wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[ADDR_W-1:3];
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= DEF_COUNT;
            text_reg    <= '0;
            len_reg     <= '0;
            max_len_reg <= DEF_MAX_LEN;
            timeout_reg <= DEF_TIMEOUT;
        end
        else if (wr_en)
        begin
            unique case (idx) inside
                REG_COUNT:   count_reg <= pwdata[2:0];
                REG_TEXT0, REG_TEXT1, REG_TEXT2, REG_TEXT3:
                begin
                    text_reg[2'(idx - REG_TEXT0)] <= pwdata;
                    len_reg[2'(idx - REG_TEXT0)]  <= text_len(pwdata, MAX_PATTERN_LEN);
                end
                REG_MAX_LEN: max_len_reg <= pwdata[CNT_W-1:0];
                REG_TIMEOUT: timeout_reg <= pwdata[CNT_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx) inside
            REG_COUNT:   prdata = DATA_W'(count_reg);
            REG_TEXT0, REG_TEXT1, REG_TEXT2, REG_TEXT3:
                         prdata = text_reg[2'(idx - REG_TEXT0)];
            REG_MAX_LEN: prdata = DATA_W'(max_len_reg);
            REG_TIMEOUT: prdata = DATA_W'(timeout_reg);
            default:     prdata = '0;
        endcase
    end

    assign cfg.count   = count_reg;
    assign cfg.text    = text_reg;
    assign cfg.len     = len_reg;
    assign cfg.max_len = max_len_reg;
    assign cfg.timeout = timeout_reg;

endmodule

[src/mpcm_cmd_queue.sv]
// Front end of the command matcher: accepts input transactions, classifies
// them as byte or tick commands and holds them in a short queue. Uses mpcm_pkg.
`timescale 1ns / 1ps

module mpcm_cmd_queue
    import mpcm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       op,
    input  logic [7:0] rx_byte,
    input  logic       handler_end,
    output logic       q_valid,
    output cmd_t       q_cmd,
    input  logic       q_pop
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

    cmd_t              mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_QW-1:0] fill_reg, fill_next;
    logic              push;
    logic              pop;
    cmd_t              new_cmd;

    assign in_stall = (fill_reg == CNT_QW'(QUEUE_DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (fill_reg != '0);
    assign pop      = q_pop && q_valid;
    assign q_cmd    = mem[rd_ptr_reg];

    assign new_cmd.is_tick = (op == OP_TICK);
    assign new_cmd.ch      = rx_byte;
    assign new_cmd.hend    = handler_end;

    always_comb
    begin
        wr_ptr_next = push ? PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = CNT_QW'(fill_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            fill_next = CNT_QW'(fill_reg - 1'b1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= new_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

[src/mpcm_engine.sv]
// Back end of the command matcher: pattern tracking, data phase, tick timeout
// and the registered result stage. Uses mpcm_pkg.
`timescale 1ns / 1ps

module mpcm_engine
    import mpcm_pkg::*;
#(
    parameter int NUM_PATTERNS = NUM_PATTERNS_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    q_valid,
    input  cmd_t    q_cmd,
    output logic    q_pop,
    output logic    out_valid,
    input  logic    out_stall,
    output result_t res
);

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    logic                         phase_reg, phase_next;
    logic [PROG_W-1:0]            prog_reg [NUM_PATTERNS];
    logic [PROG_W-1:0]            prog_next [NUM_PATTERNS];
    logic [7:0]                   last_reg, last_next;
    logic [IDX_W-1:0]             act_reg, act_next;
    logic [CNT_W-1:0]             rcnt_reg, rcnt_next;
    logic [CNT_W-1:0]             ticks_reg, ticks_next;
    logic                         out_valid_reg, out_valid_next;
    result_t                      res_reg, res_next;

    logic                         out_free;
    logic                         do_byte;
    logic                         tmo;
    logic                         any_hit;
    logic [TEXT_W-1:0]            t;
    logic [PROG_W-1:0]            len;
    logic [PROG_W-1:0]            base;
    logic [PROG_W-1:0]            base_inc;
    logic [7:0]                   lc;
    logic                         hit;
    logic [CNT_W-1:0]             rcnt_inc;

    assign out_free = !out_valid_reg || !out_stall;
    assign q_pop    = q_valid && (q_cmd.is_tick || out_free);
    assign do_byte  = q_pop && !q_cmd.is_tick;

    always_comb
    begin
        phase_next     = phase_reg;
        prog_next      = prog_reg;
        last_next      = last_reg;
        act_next       = act_reg;
        rcnt_next      = rcnt_reg;
        ticks_next     = ticks_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && out_stall;
        tmo            = 1'b0;
        any_hit        = 1'b0;
        t              = '0;
        len            = '0;
        base           = '0;
        base_inc       = '0;
        lc             = '0;
        hit            = 1'b0;
        rcnt_inc       = (rcnt_reg == CNT_MAX) ? rcnt_reg : CNT_W'(rcnt_reg + 1'b1);

        if (q_pop && q_cmd.is_tick)
        begin
            if (ticks_reg != CNT_MAX)
            begin
                ticks_next = CNT_W'(ticks_reg + 1'b1);
            end
        end

        if (do_byte)
        begin
            out_valid_next = 1'b1;
            res_next       = '0;
            tmo            = phase_reg && (ticks_reg >= cfg.timeout);
            res_next.timed_out = tmo;

            if (!phase_reg || tmo)
            begin
                // Hunting; a timeout clears all progress before the byte is seen.
                ticks_next = '0;
                phase_next = 1'b0;
                for (int i = 0; i < NUM_PATTERNS; i++)
                begin
                    base = tmo ? '0 : prog_reg[i];
                    if (i < NUM_TEXT)
                    begin
                        t   = cfg.text[2'(i)];
                        len = cfg.len[2'(i)];
                    end
                    else
                    begin
                        t   = '0;
                        len = '0;
                    end
                    if (32'(i) < 32'(cfg.count))
                    begin
                        // A string later in the order sees the byte as last
                        // character once an earlier string has advanced.
                        lc       = any_hit ? q_cmd.ch : last_reg;
                        hit      = (base < len) && (q_cmd.ch == pat_byte(t, base[2:0]));
                        base_inc = PROG_W'(base + 1'b1);
                        if (hit)
                        begin
                            any_hit      = 1'b1;
                            prog_next[i] = base_inc;
                            if (base_inc == len)
                            begin
                                act_next   = IDX_W'(i);
                                phase_next = 1'b1;
                                rcnt_next  = '0;
                                res_next.matched = 1'b1;
                            end
                        end
                        else if (len != '0 && lc == t[7:0])
                        begin
                            prog_next[i] = PROG_W'(1);
                        end
                        else
                        begin
                            prog_next[i] = '0;
                        end
                    end
                    else
                    begin
                        prog_next[i] = base;
                    end
                end
                last_next = any_hit ? q_cmd.ch : last_reg;
                res_next.pattern_index = res_next.matched ? act_next : '0;
            end
            else
            begin
                rcnt_next              = rcnt_inc;
                res_next.in_data       = 1'b1;
                res_next.pattern_index = act_reg;
                res_next.data_out      = q_cmd.ch;
                res_next.data_count    = rcnt_inc;
                if (q_cmd.hend)
                begin
                    res_next.end_reason = END_HANDLER;
                end
                else if (rcnt_inc >= cfg.max_len)
                begin
                    res_next.end_reason = END_LIMIT;
                end
                else
                begin
                    res_next.end_reason = END_NONE;
                end
                if (res_next.end_reason != END_NONE)
                begin
                    phase_next = 1'b0;
                    for (int i = 0; i < NUM_PATTERNS; i++)
                    begin
                        prog_next[i] = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= 1'b0;
            last_reg      <= '0;
            act_reg       <= '0;
            rcnt_reg      <= '0;
            ticks_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_PATTERNS; i++)
            begin
                prog_reg[i] <= '0;
            end
        end
        else
        begin
            phase_reg     <= phase_next;
            last_reg      <= last_next;
            act_reg       <= act_next;
            rcnt_reg      <= rcnt_next;
            ticks_reg     <= ticks_next;
            out_valid_reg <= out_valid_next;
            prog_reg      <= prog_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign res       = res_reg;

endmodule

[src/multi_pattern_command_matcher_core.sv]
// Multi-pattern command matcher, top level.
// Hunts for up to four configured command strings in a byte stream, then
// forwards the data bytes that follow a match with a running count.
// The input channel (in_valid / in_stall) carries byte transactions
// (op = 0) and timer tick transactions (op = 1). Every byte transaction
// gives exactly one result transaction on the output channel
// (out_valid / out_stall); a tick gives none and only advances a
// saturating tick counter used for the data-phase timeout.
// A byte accepted on the input is written into the command queue, and
// once the engine takes it from the queue head its result is registered
// in the result register. Throughput is one transaction per cycle while
// out_stall is low, set by the compare of all strings at once in the matcher engine.
// A four-entry command queue sits between the input side and the engine,
// and the result register frees as it is taken, so the input side keeps
// accepting while a result waits; when out_stall holds, the queue fills
// and in_stall rises. A tick at the queue head is still drained meanwhile.
// Reset (rst_n low, asynchronous) empties the queue, returns the engine to hunting
// with all progress and counters at zero, and loads the register defaults. The user
// must write registers over the APB-style port only while idle; the block does not enforce it.
`timescale 1ns / 1ps

module multi_pattern_command_matcher_core
    import mpcm_pkg::*;
#(
    parameter int NUM_PATTERNS    = NUM_PATTERNS_DEF,
    parameter int MAX_PATTERN_LEN = MAX_PATTERN_LEN_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              op,
    input  logic [7:0]        rx_byte,
    input  logic              handler_end,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              matched,
    output logic [IDX_W-1:0]  pattern_index,
    output logic              in_data,
    output logic [7:0]        data_out,
    output logic [CNT_W-1:0]  data_count,
    output logic              timed_out,
    output logic [1:0]        end_reason,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    cfg_t    cfg;
    cmd_t    q_cmd;
    logic    q_valid;
    logic    q_pop;
    result_t res;

    mpcm_cfg_regs #(
        .MAX_PATTERN_LEN (MAX_PATTERN_LEN)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mpcm_cmd_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .rx_byte     (rx_byte),
        .handler_end (handler_end),
        .q_valid     (q_valid),
        .q_cmd       (q_cmd),
        .q_pop       (q_pop)
    );

    mpcm_engine #(
        .NUM_PATTERNS (NUM_PATTERNS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res       (res)
    );

    assign matched       = res.matched;
    assign pattern_index = res.pattern_index;
    assign in_data       = res.in_data;
    assign data_out      = res.data_out;
    assign data_count    = res.data_count;
    assign timed_out     = res.timed_out;
    assign end_reason    = res.end_reason;

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the multi-pattern command matcher core.
// Depends on mpcm_pkg and multi_pattern_command_matcher_core; it predicts every
// result from a behavioural model of its own and compares it field by field.
`timescale 1ns / 1ps

module tb_top;
    import mpcm_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_LIMIT   = 10;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic              op = OP_BYTE;
    logic [7:0]        rx_byte = 8'd0;
    logic              handler_end = 1'b0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic              matched;
    logic [IDX_W-1:0]  pattern_index;
    logic              in_data;
    logic [7:0]        data_out;
    logic [CNT_W-1:0]  data_count;
    logic              timed_out;
    logic [1:0]        end_reason;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    multi_pattern_command_matcher_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .op            (op),
        .rx_byte       (rx_byte),
        .handler_end   (handler_end),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .matched       (matched),
        .pattern_index (pattern_index),
        .in_data       (in_data),
        .data_out      (data_out),
        .data_count    (data_count),
        .timed_out     (timed_out),
        .end_reason    (end_reason),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Register shadow, kept in step with every write over the register port
    logic [2:0]        cfg_count = DEF_COUNT;
    logic [TEXT_W-1:0] cfg_text [NUM_TEXT] = '{default: '0};
    logic [CNT_W-1:0]  cfg_max_len = DEF_MAX_LEN;
    logic [CNT_W-1:0]  cfg_timeout = DEF_TIMEOUT;

    // Matcher state as the block should hold it
    logic              phase_open = 1'b0;
    logic [PROG_W-1:0] progress [NUM_TEXT] = '{default: '0};
    logic [7:0]        last_ch = 8'd0;
    logic [IDX_W-1:0]  active_idx = '0;
    logic [CNT_W-1:0]  byte_count = '0;
    logic [CNT_W-1:0]  tick_count = '0;

    cmd_t    rx_stream [$];
    result_t predicted_results [$];
    cmd_t    driven_cmd;
    bit      calm = 1'b0;
    int      fail_count = 0;
    int      idle_cycles = 0;

    function automatic logic [7:0] str_char(input logic [TEXT_W-1:0] t, input int p);
        if (p < 0 || p > 7)
            return 8'd0;
        return t[8*p +: 8];
    endfunction

    function automatic int str_length(input logic [TEXT_W-1:0] t);
        for (int p = 0; p < 8; p++)
        begin
            if (t[8*p +: 8] == 8'd0)
                return p;
        end
        return 8;
    endfunction

    // One transaction through the matcher; a byte leaves one expected result behind
    task automatic match_step(input cmd_t c);
        result_t r;
        int      used;
        int      len;
        int      p;
        r = '0;
        if (c.is_tick)
        begin
            if (tick_count != '1)
                tick_count++;
            return;
        end
        if (phase_open && tick_count >= cfg_timeout)
        begin
            phase_open = 1'b0;
            progress = '{default: '0};
            r.timed_out = 1'b1;
        end
        if (!phase_open)
        begin
            tick_count = '0;
            used = (cfg_count > NUM_TEXT) ? NUM_TEXT : cfg_count;
            for (int i = 0; i < used; i++)
            begin
                len = str_length(cfg_text[i]);
                p = progress[i];
                if (p < len && c.ch == str_char(cfg_text[i], p))
                begin
                    last_ch = c.ch;
                    p++;
                    progress[i] = PROG_W'(p);
                    if (p == len)
                    begin
                        active_idx = IDX_W'(i);
                        phase_open = 1'b1;
                        byte_count = '0;
                        r.matched = 1'b1;
                    end
                end
                else if (len != 0 && last_ch == str_char(cfg_text[i], 0))
                    progress[i] = PROG_W'(1);
                else
                    progress[i] = '0;
            end
        end
        else
        begin
            r.in_data = 1'b1;
            r.data_out = c.ch;
            if (byte_count != '1)
                byte_count++;
            r.data_count = byte_count;
            if (c.hend)
                r.end_reason = END_HANDLER;
            else if (byte_count >= cfg_max_len)
                r.end_reason = END_LIMIT;
            if (r.end_reason != END_NONE)
            begin
                phase_open = 1'b0;
                progress = '{default: '0};
            end
        end
        if (r.matched || r.in_data)
            r.pattern_index = active_idx;
        predicted_results.push_back(r);
    endtask

    // Driver: presents queued transactions and feeds each accepted one to the model
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            op <= OP_BYTE;
            rx_byte <= 8'd0;
            handler_end <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                match_step(driven_cmd);
            if (!in_valid || !in_stall)
            begin
                if (rx_stream.size() != 0 && (calm || $urandom_range(0, 99) >= 20))
                begin
                    driven_cmd = rx_stream.pop_front();
                    in_valid <= 1'b1;
                    op <= driven_cmd.is_tick ? OP_TICK : OP_BYTE;
                    rx_byte <= driven_cmd.ch;
                    handler_end <= driven_cmd.hend;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    task automatic check_result();
        result_t got;
        result_t want;
        got = {matched, pattern_index, in_data, data_out, data_count, timed_out, end_reason};
        if (predicted_results.size() == 0)
        begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
                $display("unexpected result %p", got);
            return;
        end
        want = predicted_results.pop_front();
        if (got.matched !== want.matched || got.pattern_index !== want.pattern_index ||
            got.in_data !== want.in_data || got.data_out !== want.data_out ||
            got.data_count !== want.data_count || got.timed_out !== want.timed_out ||
            got.end_reason !== want.end_reason)
        begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
                $display("result mismatch: expected %p, got %p", want, got);
        end
    endtask

    // Monitor: takes results and stalls the output at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
                check_result();
            out_stall <= !calm && ($urandom_range(0, 99) < 20);
        end
    end

    // Ends the run if the handshakes stop moving altogether
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb_top: errors");
                $finish;
            end
        end
    end

    task automatic add_item(input logic kind, input logic [7:0] ch, input logic hend);
        cmd_t c;
        c.is_tick = (kind == OP_TICK);
        c.ch = ch;
        c.hend = hend;
        rx_stream.push_back(c);
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [DATA_W-1:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_COUNT:   cfg_count = value[2:0];
            REG_TEXT0:   cfg_text[0] = value;
            REG_TEXT1:   cfg_text[1] = value;
            REG_TEXT2:   cfg_text[2] = value;
            REG_TEXT3:   cfg_text[3] = value;
            REG_MAX_LEN: cfg_max_len = value[CNT_W-1:0];
            REG_TIMEOUT: cfg_timeout = value[CNT_W-1:0];
            default:     ;
        endcase
    endtask

    task automatic set_config(input logic [2:0] count, input logic [TEXT_W-1:0] t0,
                              input logic [TEXT_W-1:0] t1, input logic [TEXT_W-1:0] t2,
                              input logic [TEXT_W-1:0] t3, input logic [CNT_W-1:0] max_len,
                              input logic [CNT_W-1:0] tmo);
        reg_write(REG_COUNT, DATA_W'(count));
        reg_write(REG_TEXT0, t0);
        reg_write(REG_TEXT1, t1);
        reg_write(REG_TEXT2, t2);
        reg_write(REG_TEXT3, t3);
        reg_write(REG_MAX_LEN, DATA_W'(max_len));
        reg_write(REG_TIMEOUT, DATA_W'(tmo));
        @(negedge clk);
    endtask

    // Waits for the block to drain, then lets any trailing ticks work through the queue
    task automatic wait_idle();
        while (rx_stream.size() != 0 || in_valid || predicted_results.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // Strings from a small alphabet overlap often; bytes after the terminator are junk
    function automatic logic [TEXT_W-1:0] make_text(input int len);
        logic [TEXT_W-1:0] t;
        t = '0;
        for (int p = 0; p < 8; p++)
        begin
            if (p < len)
                t[8*p +: 8] = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255))
                                                          : 8'($urandom_range(8'h61, 8'h63));
            else if (p > len)
                t[8*p +: 8] = 8'($urandom_range(0, 255));
        end
        return t;
    endfunction

    task automatic add_random_traffic(input int n_bytes);
        int made;
        int pick;
        int used;
        int idx;
        int len;
        int k;
        made = 0;
        used = (cfg_count > NUM_TEXT) ? NUM_TEXT : cfg_count;
        while (made < n_bytes)
        begin
            pick = $urandom_range(0, 99);
            idx = (used == 0) ? 0 : $urandom_range(0, used - 1);
            len = str_length(cfg_text[idx]);
            if (pick < 65 && len != 0)
            begin
                // A command string, now and then cut short, then a burst of data
                k = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len - 1) : len;
                for (int p = 0; p < k; p++)
                    add_item(OP_BYTE, str_char(cfg_text[idx], p), 1'($urandom_range(0, 1)));
                made += k;
                k = $urandom_range(0, 8);
                for (int j = 0; j < k; j++)
                begin
                    if ($urandom_range(0, 5) == 0)
                        repeat ($urandom_range(1, 4)) add_item(OP_TICK, 8'($urandom), 1'b0);
                    add_item(OP_BYTE, 8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
                end
                made += k;
            end
            else if (pick < 85)
            begin
                add_item(OP_BYTE, str_char(cfg_text[idx], $urandom_range(0, 7)),
                         1'($urandom_range(0, 1)));
                made++;
            end
            else
            begin
                if ($urandom_range(0, 3) == 0)
                    add_item(OP_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                else
                begin
                    add_item(OP_BYTE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                    made++;
                end
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Register defaults: every string is empty, so nothing can match
        add_item(OP_BYTE, 8'h41, 1'b0);
        add_item(OP_BYTE, 8'h00, 1'b1);
        wait_idle();

        // "AB" and "B" complete together, the third string is empty with junk above
        // its terminator, and the fourth fills all eight bytes.
        set_config(3'd4, 64'h4241, 64'h42, 64'h5500, 64'h0102_0304_0506_80FF, 16'd3, 16'd2);
        add_item(OP_BYTE, 8'h00, 1'b1);
        add_item(OP_BYTE, 8'h41, 1'b0);
        add_item(OP_BYTE, 8'h42, 1'b0);
        add_item(OP_BYTE, 8'hFF, 1'b0);
        add_item(OP_BYTE, 8'h00, 1'b0);
        add_item(OP_BYTE, 8'h55, 1'b1);
        add_item(OP_BYTE, 8'h42, 1'b0);
        add_item(OP_BYTE, 8'h10, 1'b0);
        repeat (3) add_item(OP_TICK, 8'h00, 1'b0);
        add_item(OP_BYTE, 8'h41, 1'b0);
        add_item(OP_BYTE, 8'h42, 1'b0);
        add_item(OP_BYTE, 8'h01, 1'b0);
        add_item(OP_BYTE, 8'h02, 1'b0);
        add_item(OP_BYTE, 8'h03, 1'b0);
        for (int p = 0; p < 8; p++)
            add_item(OP_BYTE, str_char(64'h0102_0304_0506_80FF, p), 1'b0);
        add_item(OP_BYTE, 8'h7E, 1'b1);
        wait_idle();

        // No strings in use
        set_config(3'd0, 64'h4241, 64'h42, 64'h0, 64'h0, 16'd3, 16'd2);
        add_item(OP_BYTE, 8'h41, 1'b0);
        add_item(OP_BYTE, 8'h42, 1'b0);
        wait_idle();

        // Count above the number of strings, zero length limit
        set_config(3'd7, 64'h4241, 64'h42, 64'h0, 64'h43, 16'd0, 16'hFFFF);
        add_item(OP_BYTE, 8'h42, 1'b0);
        add_item(OP_BYTE, 8'h33, 1'b0);
        add_item(OP_BYTE, 8'h43, 1'b0);
        add_item(OP_TICK, 8'h00, 1'b0);
        add_item(OP_BYTE, 8'h34, 1'b0);
        wait_idle();

        // Zero timeout: the byte after a match already finds the phase expired
        set_config(3'd5, 64'h4241, 64'h42, 64'h0, 64'h0, 16'hFFFF, 16'd0);
        add_item(OP_BYTE, 8'h42, 1'b0);
        add_item(OP_BYTE, 8'h44, 1'b0);
        add_item(OP_BYTE, 8'h42, 1'b1);
        wait_idle();

        for (int ph = 0; ph < 5; ph++)
        begin
            calm = (ph == 1);
            case (ph)
                0: set_config(3'd4, make_text($urandom_range(1, 4)),
                              make_text($urandom_range(0, 4)), make_text($urandom_range(1, 3)),
                              make_text($urandom_range(0, 8)), 16'd4, 16'd3);
                1: set_config(3'd2, make_text($urandom_range(1, 8)),
                              make_text($urandom_range(1, 8)), make_text($urandom_range(0, 8)),
                              make_text($urandom_range(0, 8)), 16'd1, 16'd1);
                2: set_config(3'd3, make_text($urandom_range(1, 3)),
                              make_text($urandom_range(1, 6)), make_text($urandom_range(0, 2)),
                              make_text($urandom_range(0, 8)), 16'hFFFF, 16'hFFFF);
                3: set_config(3'd5, make_text($urandom_range(1, 2)),
                              make_text($urandom_range(1, 4)), make_text($urandom_range(1, 5)),
                              make_text($urandom_range(1, 8)), 16'd6, 16'd5);
                default: set_config(3'd1, make_text($urandom_range(1, 5)),
                                    make_text($urandom_range(0, 8)),
                                    make_text($urandom_range(0, 8)),
                                    make_text($urandom_range(0, 8)), 16'd2, 16'd2);
            endcase
            add_random_traffic(80);
            wait_idle();
        end
        calm = 1'b0;

        if (fail_count == 0 && predicted_results.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
